>>> rtl/bms_pkg.sv
// Package for the bounded multiset table: mode codes, field widths and the
// result record passed from the sequencer to the output stage.
// No dependencies.
package bms_pkg;

	localparam int MODE_W  = 2;
	localparam int FIELD_W = 5;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] frequency;
		logic [FIELD_W-1:0] entry_count;
		logic               is_empty;
	} bms_res_t;

endpackage

>>> rtl/bms_if.sv
// Channel interfaces of the bounded multiset table: command in, result out.
// Depends on bms_pkg for field widths.
interface bms_cmd_if #(
	parameter int KEY_WIDTH = 32
);
	logic                        valid;
	logic                        ready;
	logic [bms_pkg::MODE_W-1:0]  mode;
	logic [KEY_WIDTH-1:0]        key;

	modport source (output valid, mode, key, input ready);
	modport sink   (input valid, mode, key, output ready);
endinterface

interface bms_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [bms_pkg::FIELD_W-1:0] frequency;
	logic [bms_pkg::FIELD_W-1:0] entry_count;
	logic                        is_empty;

	modport source (output valid, ok, frequency, entry_count, is_empty, input ready);
	modport sink   (input valid, ok, frequency, entry_count, is_empty, output ready);
endinterface

>>> rtl/bms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/bms_ctrl.sv
// Sequencer of the bounded multiset table: owns the entry count, scans the
// entry RAM for remove and query, and does the move of the last entry.
// Depends on bms_pkg and bms_ram.
module bms_ctrl #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bms_pkg::CFG_W-1:0]    max_entries,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bms_pkg::MODE_W-1:0]   mode,
	input  logic [KEY_WIDTH-1:0]         key,
	output logic                         res_valid,
	output bms_pkg::bms_res_t            res,
	input  logic                         res_ready
);
	import bms_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_MOVE  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        freq_q;
	logic [AW-1:0]        pos_q;
	logic [KEY_WIDTH-1:0] key_q;
	mode_t                op_q;
	logic                 ok_q;
	logic                 pend_s1;
	logic [AW-1:0]        pend_idx_s1;

	logic                 accept;
	logic                 can_add;
	logic                 issue;
	logic                 hit;
	logic [CW-1:0]        cnt_m1;
	logic [CW+4:0]        freq_ext;
	logic [CW+4:0]        cnt_ext;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [KEY_WIDTH-1:0] ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_m1   = cnt_q - CW'(1);

	// effective limit is min(max_entries, CAPACITY)
	assign can_add = ({{CW{1'b0}}, max_entries} > {5'b0, cnt_q}) &&
	                 (cnt_q < CW'(CAPACITY));

	assign issue = (idx_q != cnt_q);
	assign hit   = pend_s1 && (ram_rdata == key_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = key;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		if (accept && mode_t'(mode) == MODE_ADD && can_add) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = ram_rdata;
		end
		if (state_q == ST_SCAN && issue) begin
			ram_re = 1'b1;
		end
		if (state_q == ST_MOVE) begin
			ram_re    = 1'b1;
			ram_raddr = cnt_m1[AW-1:0];
		end
	end

	bms_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= mode_t'(mode);
						key_q  <= key;
						freq_q <= '0;
						idx_q  <= '0;
						pend_s1 <= 1'b0;
						unique case (mode_t'(mode))
							MODE_ADD: begin
								ok_q <= can_add;
								if (can_add) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= ST_RESP;
							end
							MODE_REMOVE, MODE_QUERY: begin
								state_q <= ST_SCAN;
							end
							MODE_CLEAR: begin
								cnt_q   <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_RESP;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCAN: begin
					if (op_q == MODE_REMOVE && hit) begin
						pos_q   <= pend_idx_s1;
						pend_s1 <= 1'b0;
						state_q <= ST_MOVE;
					end else if (!issue && !pend_s1) begin
						ok_q    <= (op_q == MODE_QUERY) && (freq_q != '0);
						state_q <= ST_RESP;
					end else begin
						pend_s1     <= issue;
						pend_idx_s1 <= idx_q[AW-1:0];
						if (issue) begin
							idx_q <= idx_q + CW'(1);
						end
						if (op_q == MODE_QUERY && hit) begin
							freq_q <= freq_q + CW'(1);
						end
					end
				end
				ST_MOVE: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					cnt_q   <= cnt_m1;
					ok_q    <= 1'b1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// counts go out modulo 32 on the five-bit result fields
	assign freq_ext = {5'b0, freq_q};
	assign cnt_ext  = {5'b0, cnt_q};

	assign res_valid       = (state_q == ST_RESP);
	assign res.ok          = ok_q;
	assign res.frequency   = freq_ext[FIELD_W-1:0];
	assign res.entry_count = cnt_ext[FIELD_W-1:0];
	assign res.is_empty    = (cnt_q == '0);
endmodule

>>> rtl/bounded_multiset_table.sv
// Top level of the bounded multiset table: configuration register, sequencer
// and output register. Depends on bms_pkg, bms_if, bms_ram and bms_ctrl.
//
//  channel   dir  handshake        payload
//  cmd       in   valid/ready      mode, key
//  rsp       out  valid/ready      ok, frequency, entry_count, is_empty
//  cfg       in   cfg_we           cfg_wdata -> max_entries
//
// One item at a time. Add and clear go from acceptance to the result state and then
// into the output register; query and remove scan the entries below the count, one
// entry a cycle through the single read port of the entry RAM (a remove stops at
// the first match and then reads the last entry and writes it into the hole). Reset
// clears the count and sequencer; the entry RAM is not cleared, only entries below
// the count are ever read. A stalled rsp holds the result in the output register
// while the next item is taken and worked on; the sequencer waits only when that
// register is full.
module bounded_multiset_table #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bms_pkg::CFG_W-1:0] cfg_wdata,
	bms_cmd_if.sink                   cmd,
	bms_rsp_if.source                 rsp
);
	import bms_pkg::*;

	logic [CFG_W-1:0] max_entries_q;
	logic             res_valid;
	logic             res_ready;
	bms_res_t         res;
	logic             rsp_valid_q;
	bms_res_t         rsp_q;

	// capacity limit; a value above CAPACITY saturates in the add check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	bms_ctrl #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_entries (max_entries_q),
		.in_valid    (cmd.valid),
		.in_ready    (cmd.ready),
		.mode        (cmd.mode),
		.key         (cmd.key),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_q.ok;
	assign rsp.frequency   = rsp_q.frequency;
	assign rsp.entry_count = rsp_q.entry_count;
	assign rsp.is_empty    = rsp_q.is_empty;

	// one item in flight: the sequencer is busy the cycle after acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while previous item still at work");

	// a finished result waiting for the output register must hold
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while waiting for output register");

	// a nonzero frequency only comes from a query that found the key
	a_freq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.frequency != '0) |-> rsp.ok)
		else $error("nonzero frequency reported with ok low");

	// the output register holds while the sink stalls
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp_q))
		else $error("output item dropped or changed under stall");
endmodule
